[hdl/brf_pkg.sv]
// shared types and constants for the byte ring fifo
`timescale 1ns / 1ps

package brf_pkg;

  localparam int REQ_W   = 2;
  localparam int DATA_W  = 8;
  localparam int COUNT_W = 11;

  localparam logic [REQ_W-1:0] REQ_WRITE = 2'd0;
  localparam logic [REQ_W-1:0] REQ_READ  = 2'd1;
  localparam logic [REQ_W-1:0] REQ_SKIP  = 2'd2;

  // controller to datapath
  typedef struct packed {
    logic exec;       // transaction taken this cycle, apply it
    logic load_read;  // store read data is ready, capture it
  } brf_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic read_hit;   // presented transaction is a read of a non-empty buffer
  } brf_stat_t;

endpackage

[hdl/brf_ram.sv]
// generic single write port ram with registered read
`timescale 1ns / 1ps

module brf_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic                     re,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[hdl/brf_ctrl.sv]
// handshake controller for the byte ring fifo
`timescale 1ns / 1ps

module brf_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_stall,
  output logic               out_valid,
  input  logic               out_stall,
  input  brf_pkg::brf_stat_t st,
  output brf_pkg::brf_cmd_t  cmd
);

  localparam logic S_IDLE  = 1'b0;
  localparam logic S_RWAIT = 1'b1;

  logic state;
  logic state_next;
  logic out_valid_next;
  logic take;

  // output slot is free when empty or being drained this cycle
  assign in_stall = !((state == S_IDLE) && (!out_valid || !out_stall));
  assign take     = in_valid && !in_stall;

  assign cmd.exec      = take;
  assign cmd.load_read = (state == S_RWAIT);

  always_comb begin
    state_next     = state;
    out_valid_next = out_valid;
    if (out_valid && !out_stall) begin
      out_valid_next = 1'b0;
    end
    unique case (state)
      S_IDLE: begin
        if (take) begin
          if (st.read_hit) begin
            state_next = S_RWAIT;
          end else begin
            out_valid_next = 1'b1;
          end
        end
      end
      S_RWAIT: begin
        state_next     = S_IDLE;
        out_valid_next = 1'b1;
      end
      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      out_valid <= 1'b0;
    end else begin
      state     <= state_next;
      out_valid <= out_valid_next;
    end
  end

  a_read_waits: assert property (@(posedge clk) disable iff (rst)
    take && st.read_hit |=> (state == S_RWAIT) && !out_valid)
    else $error("read transaction did not wait for store data");

  a_rwait_done: assert property (@(posedge clk) disable iff (rst)
    (state == S_RWAIT) |=> out_valid && (state == S_IDLE))
    else $error("read result not presented after store access");

  a_no_overwrite: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |-> !take && !cmd.load_read)
    else $error("pending result would be overwritten");

endmodule

[hdl/brf_dpath.sv]
// pointers, byte store and result registers of the byte ring fifo
`timescale 1ns / 1ps

module brf_dpath #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic [brf_pkg::REQ_W-1:0]         req_type,
  input  logic [brf_pkg::DATA_W-1:0]        write_data,
  input  logic [brf_pkg::COUNT_W-1:0]       skip_count,
  input  brf_pkg::brf_cmd_t                 cmd,
  output brf_pkg::brf_stat_t                st,
  output logic                              accepted,
  output logic [brf_pkg::DATA_W-1:0]        read_data,
  output logic [brf_pkg::COUNT_W-1:0]       skipped,
  output logic [brf_pkg::COUNT_W-1:0]       occupancy
);

  localparam int IDX_W = $clog2(DEPTH);
  localparam int PTR_W = IDX_W + 1;
  localparam int CMP_W = (PTR_W > brf_pkg::COUNT_W) ? PTR_W : brf_pkg::COUNT_W;

  logic [PTR_W-1:0] wr_ptr;
  logic [PTR_W-1:0] rd_ptr;
  logic [PTR_W-1:0] wr_ptr_next;
  logic [PTR_W-1:0] rd_ptr_next;
  logic [PTR_W-1:0] fill;
  logic [PTR_W-1:0] fill_after;
  logic [PTR_W-1:0] skip_amt;
  logic [CMP_W-1:0] fill_ext;
  logic [CMP_W-1:0] count_ext;
  logic [CMP_W-1:0] skip_ext;
  logic [CMP_W-1:0] occ_ext;
  logic [CMP_W-1:0] skip_out;
  logic             full;
  logic             empty;
  logic             write_hit;
  logic             read_hit;
  logic             ram_we;
  logic             ram_re;
  logic [brf_pkg::DATA_W-1:0] ram_rdata;

  // pointers run modulo 2*DEPTH, so the difference is the fill level
  assign fill  = wr_ptr - rd_ptr;
  assign full  = (fill == PTR_W'(DEPTH));
  assign empty = (fill == '0);

  assign fill_ext  = CMP_W'(fill);
  assign count_ext = CMP_W'(skip_count);
  assign skip_ext  = (count_ext < fill_ext) ? count_ext : fill_ext;
  assign skip_amt  = skip_ext[PTR_W-1:0];

  always_comb begin
    write_hit   = 1'b0;
    read_hit    = 1'b0;
    skip_out    = '0;
    wr_ptr_next = wr_ptr;
    rd_ptr_next = rd_ptr;
    fill_after  = fill;
    unique case (req_type)
      brf_pkg::REQ_WRITE: begin
        write_hit = !full;
        if (!full) begin
          wr_ptr_next = wr_ptr + PTR_W'(1);
          fill_after  = fill + PTR_W'(1);
        end
      end
      brf_pkg::REQ_READ: begin
        read_hit = !empty;
        if (!empty) begin
          rd_ptr_next = rd_ptr + PTR_W'(1);
          fill_after  = fill - PTR_W'(1);
        end
      end
      brf_pkg::REQ_SKIP: begin
        skip_out    = skip_ext;
        rd_ptr_next = rd_ptr + skip_amt;
        fill_after  = fill - skip_amt;
      end
      default: begin
        // unused code: no operation
      end
    endcase
  end

  assign occ_ext     = CMP_W'(fill_after);
  assign st.read_hit = read_hit;
  assign ram_we      = cmd.exec && write_hit;
  assign ram_re      = cmd.exec && read_hit;

  brf_ram #(
    .WIDTH (brf_pkg::DATA_W),
    .DEPTH (DEPTH)
  ) u_store (
    .clk   (clk),
    .we    (ram_we),
    .waddr (wr_ptr[IDX_W-1:0]),
    .wdata (write_data),
    .re    (ram_re),
    .raddr (rd_ptr[IDX_W-1:0]),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else if (cmd.exec) begin
      wr_ptr <= wr_ptr_next;
      rd_ptr <= rd_ptr_next;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.exec) begin
      accepted  <= write_hit || read_hit;
      read_data <= '0;
      skipped   <= skip_out[brf_pkg::COUNT_W-1:0];
      occupancy <= occ_ext[brf_pkg::COUNT_W-1:0];
    end else if (cmd.load_read) begin
      read_data <= ram_rdata;
    end
  end

  a_fill_bound: assert property (@(posedge clk) disable iff (rst)
    fill <= PTR_W'(DEPTH))
    else $error("fill level beyond capacity");

  a_one_port_op: assert property (@(posedge clk) disable iff (rst)
    !(ram_we && ram_re))
    else $error("store written and read by one transaction");

  a_load_after_read: assert property (@(posedge clk) disable iff (rst)
    cmd.load_read |-> $past(ram_re))
    else $error("read data captured without a store read");

endmodule

[hdl/byte_ring_fifo_unit.sv]
// top level of the byte ring fifo
`timescale 1ns / 1ps

// Byte FIFO over a DEPTH-entry store (DEPTH a power of two, 2 to 1024). Each
// transaction writes one byte, reads one byte or discards up to skip_count
// unread bytes (clamped to the fill level), and returns one result with the
// fill level after it. Writes, skips, refused requests and reads of an empty
// buffer answer in the next cycle; a successful read waits in S_RWAIT for the
// registered read port of the byte store, with the input stalled. The result
// sits in an output register, so the next transaction is taken in the cycle
// the pending result is drained. No clearing pass follows reset.

module byte_ring_fifo_unit #(
  parameter int DEPTH = 1024
) (
  input  logic                              clk,
  input  logic                              rst,
  input  logic                              in_valid,
  output logic                              in_stall,
  input  logic [brf_pkg::REQ_W-1:0]         req_type,
  input  logic [brf_pkg::DATA_W-1:0]        write_data,
  input  logic [brf_pkg::COUNT_W-1:0]       skip_count,
  output logic                              out_valid,
  input  logic                              out_stall,
  output logic                              accepted,
  output logic [brf_pkg::DATA_W-1:0]        read_data,
  output logic [brf_pkg::COUNT_W-1:0]       skipped,
  output logic [brf_pkg::COUNT_W-1:0]       occupancy
);

  brf_pkg::brf_cmd_t  cmd;
  brf_pkg::brf_stat_t st;

  brf_ctrl u_ctrl (
    .clk       (clk),
    .rst       (rst),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .out_valid (out_valid),
    .out_stall (out_stall),
    .st        (st),
    .cmd       (cmd)
  );

  brf_dpath #(
    .DEPTH (DEPTH)
  ) u_dpath (
    .clk        (clk),
    .rst        (rst),
    .req_type   (req_type),
    .write_data (write_data),
    .skip_count (skip_count),
    .cmd        (cmd),
    .st         (st),
    .accepted   (accepted),
    .read_data  (read_data),
    .skipped    (skipped),
    .occupancy  (occupancy)
  );

endmodule
